>>> hw/rtl/bcs_pkg.sv
// blit command setup package: widths, opcode, status and register codes,
// controller command struct and the clip helper. no dependencies.
`default_nettype none

package bcs_pkg;

  // field widths
  localparam int ADDR_W  = 48;
  localparam int COORD_W = 12;
  localparam int SIZE_W  = 13;
  localparam int PITCH_W = 17;
  localparam int ROW_W   = 15;
  localparam int PROD_W  = ROW_W + PITCH_W;
  localparam int COLOR_W = 32;
  localparam int PAN_W   = 14;

  // pixel size is fixed at four bytes
  localparam int BYTES_PER_PIXEL = 4;
  localparam int BPP_SHIFT       = $clog2(BYTES_PER_PIXEL);

  localparam int MAX_BUFFERS_DEF = 2;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_PITCH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_COUNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HOST_SYNC     = 3'd5;

  // opcodes
  localparam logic [1:0] OP_FILL = 2'd0;
  localparam logic [1:0] OP_COPY = 2'd1;
  localparam logic [1:0] OP_PAN  = 2'd2;

  // result status
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // capture a new command word
    logic check;   // validate, clip, form row numbers
    logic mul_t;   // target row times pitch
    logic add_t;   // target address sum, source row times pitch
    logic finish;  // source address sum, load result word
  } ctrl_cmd_t;

  // clip a span to the right or bottom screen edge
  function automatic logic [SIZE_W-1:0] clip_len(input logic [SIZE_W-1:0] start,
                                                 input logic [SIZE_W-1:0] len,
                                                 input logic [SIZE_W-1:0] limit);
    logic [SIZE_W:0] sum;
    sum = {1'b0, start} + {1'b0, len};
    return (sum > {1'b0, limit}) ? SIZE_W'(limit - start) : len;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/bcs_if.sv
// command and result channel interfaces of the blit command setup block
// depends on bcs_pkg for field widths
`default_nettype none

interface bcs_cmd_if;
  import bcs_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           opcode;
  logic [1:0]           source_buffer;
  logic [COORD_W-1:0]   source_x;
  logic [COORD_W-1:0]   source_y;
  logic [1:0]           target_buffer;
  logic [COORD_W-1:0]   target_x;
  logic [COORD_W-1:0]   target_y;
  logic [COORD_W-1:0]   rect_width;
  logic [COORD_W-1:0]   rect_height;
  logic [COLOR_W-1:0]   fill_color;
  logic [PAN_W-1:0]     pan_row_offset;

  modport source (output valid, opcode, source_buffer, source_x, source_y, target_buffer,
                  target_x, target_y, rect_width, rect_height, fill_color, pan_row_offset,
                  input ready);
  modport sink (input valid, opcode, source_buffer, source_x, source_y, target_buffer,
                target_x, target_y, rect_width, rect_height, fill_color, pan_row_offset,
                output ready);
endinterface

interface bcs_res_if;
  import bcs_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [ADDR_W-1:0]    target_address;
  logic [ADDR_W-1:0]    source_address;
  logic [SIZE_W-1:0]    clipped_width;
  logic [SIZE_W-1:0]    clipped_height;
  logic [COLOR_W-1:0]   color_out;
  logic                 present_request;
  logic                 displayed_index;

  modport source (output valid, status, target_address, source_address, clipped_width,
                  clipped_height, color_out, present_request, displayed_index,
                  input ready);
  modport sink (input valid, status, target_address, source_address, clipped_width,
                clipped_height, color_out, present_request, displayed_index,
                output ready);
endinterface

`default_nettype wire

>>> hw/rtl/blit_command_setup_core.sv
// blit command setup top level: 2D fill/copy/pan command checks, clipping and
// start address setup. an accepted word passes check, target multiply, target
// add and source add steps; the target multiply and target add steps share one
// row-times-pitch multiplier; the source add waits for a free result slot.
// a new command is accepted in the cycle the previous result word is loaded.
// synchronous reset restores the default screen registers and shows buffer 0.
`default_nettype none

module blit_command_setup_core #(
  parameter int MAX_BUFFERS = bcs_pkg::MAX_BUFFERS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [bcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bcs_pkg::CFG_DATA_W-1:0] cfg_data,
  bcs_cmd_if.sink                            cmd,
  bcs_res_if.source                          res
);
  import bcs_pkg::*;

  ctrl_cmd_t ctl;
  logic      in_ready;
  logic      out_valid;

  assign cmd.ready = in_ready;
  assign res.valid = out_valid;

  // sequencer
  bcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (res.ready),
    .cmd       (ctl)
  );

  // checks, clipping and address arithmetic
  bcs_datapath #(
    .MAX_BUFFERS (MAX_BUFFERS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (ctl),
    .cmd_in    (cmd),
    .res       (res)
  );

endmodule

`default_nettype wire

>>> hw/rtl/bcs_ctrl.sv
// sequencing state machine of the blit command setup block
// depends on bcs_pkg for the command struct
`default_nettype none

module bcs_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output bcs_pkg::ctrl_cmd_t      cmd
);
  import bcs_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_ADDT  = 3'd3;
  localparam logic [2:0] S_ADDS  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;
  logic       finish;
  logic       accept;

  // result slot frees when empty or taken this cycle
  assign out_free = !out_valid || out_ready;
  assign finish   = (state == S_ADDS) && out_free;
  assign in_ready = (state == S_IDLE) || finish;
  assign accept   = in_valid && in_ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  state_next = accept ? S_CHECK : S_IDLE;
      S_CHECK: state_next = S_MUL;
      S_MUL:   state_next = S_ADDT;
      S_ADDT:  state_next = S_ADDS;
      S_ADDS: begin
        if (finish) begin
          state_next = accept ? S_CHECK : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath commands
  assign cmd.load   = accept;
  assign cmd.check  = (state == S_CHECK);
  assign cmd.mul_t  = (state == S_MUL);
  assign cmd.add_t  = (state == S_ADDT);
  assign cmd.finish = finish;

  // a new word always starts with the check step
  a_accept_check: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_CHECK)
    else $error("accepted word did not enter check step");

  // a finished word is offered at the output
  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    finish |=> out_valid)
    else $error("finished word not offered");

  // no new word while the address unit is busy
  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK || state == S_MUL || state == S_ADDT) |-> !in_ready)
    else $error("input ready while busy");

endmodule

`default_nettype wire

>>> hw/rtl/bcs_datapath.sv
// datapath of the blit command setup block: configuration registers, shown
// buffer, checks and clipping, shared address multiplier, result register
// depends on bcs_pkg and the channel interfaces in bcs_if
`default_nettype none

module bcs_datapath #(
  parameter int MAX_BUFFERS = bcs_pkg::MAX_BUFFERS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [bcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bcs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire bcs_pkg::ctrl_cmd_t            cmd,
  bcs_cmd_if.sink                            cmd_in,
  bcs_res_if.source                          res
);
  import bcs_pkg::*;

  localparam int BUF_W = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;

  // configuration registers
  logic [SIZE_W-1:0]  scr_w;
  logic [SIZE_W-1:0]  scr_h;
  logic [PITCH_W-1:0] pitch;
  logic [1:0]         buf_cnt;
  logic [ADDR_W-1:0]  base;
  logic               host_sync;

  // buffer on screen
  logic [BUF_W-1:0]   shown;
  logic [BUF_W-1:0]   shown_next;

  // captured command word
  logic [1:0]         op_r;
  logic [1:0]         sb_r;
  logic [COORD_W-1:0] sx_r;
  logic [COORD_W-1:0] sy_r;
  logic [1:0]         tb_r;
  logic [COORD_W-1:0] tx_r;
  logic [COORD_W-1:0] ty_r;
  logic [COORD_W-1:0] rw_r;
  logic [COORD_W-1:0] rh_r;
  logic [COLOR_W-1:0] color_r;
  logic [PAN_W-1:0]   pan_r;

  // results of the check step
  logic [1:0]         status_r;
  logic [SIZE_W-1:0]  cw_r;
  logic [SIZE_W-1:0]  ch_r;
  logic               present_r;
  logic [COORD_W-1:0] xt_r;
  logic [ROW_W-1:0]   row_t_r;
  logic [ROW_W-1:0]   row_s_r;

  // address unit
  logic [PROD_W-1:0]  prod_r;
  logic [ADDR_W-1:0]  taddr_r;
  logic [ROW_W-1:0]   mul_a;
  logic [ADDR_W-1:0]  saddr_c;

  // check step logic
  logic [1:0]         nbuf;
  logic               empty;
  logic               t_bad;
  logic               s_bad;
  logic               pan_hit;
  logic [BUF_W-1:0]   pan_idx;
  logic [1:0]         status_c;
  logic [SIZE_W-1:0]  cw_c;
  logic [SIZE_W-1:0]  ch_c;
  logic               present_c;
  logic [1:0]         t_buf;
  logic [COORD_W-1:0] t_x;
  logic [COORD_W-1:0] t_y;
  logic [ROW_W-1:0]   row_t_c;
  logic [ROW_W-1:0]   row_s_c;
  logic               done_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      scr_w     <= SIZE_W'(1280);
      scr_h     <= SIZE_W'(800);
      pitch     <= PITCH_W'(5120);
      buf_cnt   <= 2'd1;
      base      <= '0;
      host_sync <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH:  scr_w     <= cfg_data[SIZE_W-1:0];
        CFG_SCREEN_HEIGHT: scr_h     <= cfg_data[SIZE_W-1:0];
        CFG_LINE_PITCH:    pitch     <= cfg_data[PITCH_W-1:0];
        CFG_BUFFER_COUNT:  buf_cnt   <= cfg_data[1:0];
        CFG_BASE_ADDRESS:  base      <= cfg_data[ADDR_W-1:0];
        CFG_HOST_SYNC:     host_sync <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // capture the command word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= cmd_in.opcode;
      sb_r    <= cmd_in.source_buffer;
      sx_r    <= cmd_in.source_x;
      sy_r    <= cmd_in.source_y;
      tb_r    <= cmd_in.target_buffer;
      tx_r    <= cmd_in.target_x;
      ty_r    <= cmd_in.target_y;
      rw_r    <= cmd_in.rect_width;
      rh_r    <= cmd_in.rect_height;
      color_r <= cmd_in.fill_color;
      pan_r   <= cmd_in.pan_row_offset;
    end
  end

  // effective buffer count, capped at the build limit
  assign nbuf = (3'(buf_cnt) > 3'(MAX_BUFFERS)) ? 2'(MAX_BUFFERS) : buf_cnt;

  assign empty = (rw_r == '0) || (rh_r == '0);
  assign t_bad = ({1'b0, tx_r} >= scr_w) || ({1'b0, ty_r} >= scr_h) || (tb_r >= nbuf);
  assign s_bad = ({1'b0, sx_r} >= scr_w) || ({1'b0, sy_r} >= scr_h) || (sb_r >= nbuf);

  // pan offset must land exactly on the start of an existing buffer
  always_comb begin
    pan_hit = 1'b0;
    pan_idx = '0;
    for (int k = 0; k < MAX_BUFFERS; k++) begin
      if ((3'(k) < {1'b0, nbuf}) &&
          (ROW_W'(pan_r) == ROW_W'(ROW_W'(k) * ROW_W'(scr_h)))) begin
        pan_hit = 1'b1;
        pan_idx = BUF_W'(k);
      end
    end
  end

  // command decode, validity and clipping
  always_comb begin
    status_c   = ST_DONE;
    cw_c       = '0;
    ch_c       = '0;
    present_c  = 1'b0;
    shown_next = shown;
    case (op_r)
      OP_FILL: begin
        if (empty) begin
          status_c = ST_EMPTY;
        end else if (t_bad) begin
          status_c = ST_INVALID;
        end else begin
          cw_c      = clip_len(SIZE_W'(tx_r), SIZE_W'(rw_r), scr_w);
          ch_c      = clip_len(SIZE_W'(ty_r), SIZE_W'(rh_r), scr_h);
          present_c = host_sync && (tb_r == 2'(shown));
        end
      end
      OP_COPY: begin
        if (empty) begin
          status_c = ST_EMPTY;
        end else if (t_bad || s_bad) begin
          status_c = ST_INVALID;
        end else begin
          cw_c      = clip_len(SIZE_W'(tx_r),
                               clip_len(SIZE_W'(sx_r), SIZE_W'(rw_r), scr_w), scr_w);
          ch_c      = clip_len(SIZE_W'(ty_r),
                               clip_len(SIZE_W'(sy_r), SIZE_W'(rh_r), scr_h), scr_h);
          present_c = host_sync && (tb_r == 2'(shown));
        end
      end
      OP_PAN: begin
        if (host_sync) begin
          present_c = (scr_w != '0) && (scr_h != '0);
        end else if ((nbuf > 2'd1) && (scr_h != '0)) begin
          if (pan_hit) begin
            shown_next = pan_idx;
          end else begin
            status_c = ST_INVALID;
          end
        end
        if (status_c == ST_DONE) begin
          cw_c = scr_w;
          ch_c = scr_h;
        end
      end
      default: status_c = ST_INVALID;
    endcase
  end

  // row numbers: pan addresses the top left of the shown buffer
  always_comb begin
    if (op_r == OP_PAN) begin
      t_buf = 2'(shown_next);
      t_x   = '0;
      t_y   = '0;
    end else begin
      t_buf = tb_r;
      t_x   = tx_r;
      t_y   = ty_r;
    end
  end

  assign row_t_c = ROW_W'(ROW_W'(t_buf) * ROW_W'(scr_h)) + ROW_W'(t_y);
  assign row_s_c = ROW_W'(ROW_W'(sb_r) * ROW_W'(scr_h)) + ROW_W'(sy_r);

  // shown buffer follows a valid pan
  always_ff @(posedge clk) begin
    if (rst) begin
      shown <= '0;
    end else if (cmd.check) begin
      shown <= shown_next;
    end
  end

  // check step registers
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      status_r  <= status_c;
      cw_r      <= cw_c;
      ch_r      <= ch_c;
      present_r <= present_c;
      xt_r      <= t_x;
      row_t_r   <= row_t_c;
      row_s_r   <= row_s_c;
    end
  end

  // shared multiplier: target row first, then source row
  assign mul_a = cmd.add_t ? row_s_r : row_t_r;

  always_ff @(posedge clk) begin
    if (cmd.mul_t || cmd.add_t) begin
      prod_r <= PROD_W'(mul_a * PROD_W'(pitch));
    end
    if (cmd.add_t) begin
      taddr_r <= base + ADDR_W'(prod_r) + (ADDR_W'(xt_r) << BPP_SHIFT);
    end
  end

  assign saddr_c = base + ADDR_W'(prod_r) + (ADDR_W'(sx_r) << BPP_SHIFT);
  assign done_r  = (status_r == ST_DONE);

  // result word register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res.status          <= status_r;
      res.target_address  <= done_r ? taddr_r : '0;
      res.source_address  <= (done_r && (op_r == OP_COPY)) ? saddr_c : '0;
      res.clipped_width   <= cw_r;
      res.clipped_height  <= ch_r;
      res.color_out       <= (done_r && (op_r == OP_FILL)) ? color_r : '0;
      res.present_request <= present_r;
      res.displayed_index <= shown[0];
    end
  end

  // a word that is not done carries no addresses or sizes
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.finish && !done_r |=> res.target_address == '0 && res.source_address == '0 &&
                              res.clipped_width == '0 && res.clipped_height == '0 &&
                              !res.present_request)
    else $error("failed command carries payload");

  // a done fill or copy stays inside the screen
  a_clip_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.finish && done_r && (op_r == OP_FILL || op_r == OP_COPY) |=>
      res.clipped_width <= scr_w && res.clipped_height <= scr_h)
    else $error("clipped size beyond screen");

  // the shown buffer changes only in the check step
  a_shown_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.check |=> $stable(shown))
    else $error("shown buffer changed outside check step");

endmodule

`default_nettype wire
